FILE: design/polyphase_resampler_top_macros.svh
// Assertion macros shared by the resampler RTL.
`ifndef POLYPHASE_RESAMPLER_TOP_MACROS_SVH
`define POLYPHASE_RESAMPLER_TOP_MACROS_SVH
`ifndef SYNTHESIS
// Checked at every clock edge outside reset.
`define RSMP_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);
// Checked at every clock edge, reset included.
`define RSMP_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) else $error(msg);
`else
`define RSMP_ASSERT(lbl, prop, msg)
`define RSMP_ASSERT_ALWAYS(lbl, prop, msg)
`endif
`endif

FILE: design/rsmp_pkg.sv
// Shared constants and types of the polyphase resampler.
package rsmp_pkg;

  // Coefficient store addressing, fixed by the coefficient index field.
  localparam int STORE_AW    = 9;
  localparam int STORE_DEPTH = 512;

  // Largest effective decimation factor.
  localparam int MAX_DOWN = 256;

  // Skip counter.
  localparam int SKIP_W   = 8;
  localparam int SKIP_MAX = 255;

  // Configuration register widths and reset values.
  localparam int UP_REG_W   = 5;
  localparam int DOWN_REG_W = 9;
  localparam int TAPS_REG_W = 6;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 9;

  localparam logic [UP_REG_W-1:0]   UP_RESET   = 5'd1;
  localparam logic [DOWN_REG_W-1:0] DOWN_RESET = 9'd1;
  localparam logic [TAPS_REG_W-1:0] TAPS_RESET = 6'd32;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] REG_UP_RATE        = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_DOWN_RATE      = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_TAPS_PER_PHASE = 2'd2;

  // Input item kinds.
  localparam logic FUNC_SAMPLE = 1'b0;
  localparam logic FUNC_COEF   = 1'b1;

  // Control of the shared multiply-accumulate unit.
  typedef struct packed {
    logic clr;  // zero the accumulator
    logic vld;  // a tap is issued this cycle
  } mac_ctrl_t;

endpackage

FILE: design/rsmp_coef_mem.sv
// Coefficient store: single-port write, registered read, zeroing sweep after reset.
module rsmp_coef_mem #(
  parameter int COEF_WIDTH = 18
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              wr_en_i,
  input  logic [rsmp_pkg::STORE_AW-1:0]     wr_addr_i,
  input  logic signed [COEF_WIDTH-1:0]      wr_data_i,
  input  logic [rsmp_pkg::STORE_AW-1:0]     rd_addr_i,
  output logic signed [COEF_WIDTH-1:0]      rd_data_o,
  output logic                              ready_o
);
  import rsmp_pkg::*;

  logic signed [COEF_WIDTH-1:0] mem [STORE_DEPTH];
  logic signed [COEF_WIDTH-1:0] rd_data_q;
  logic                         clr_busy_q, clr_busy_d;
  logic [STORE_AW-1:0]          clr_addr_q, clr_addr_d;
  logic                         we;
  logic [STORE_AW-1:0]          waddr;
  logic signed [COEF_WIDTH-1:0] wdata;

  always_comb begin
    clr_busy_d = clr_busy_q;
    clr_addr_d = clr_addr_q;
    if (clr_busy_q) begin
      clr_addr_d = clr_addr_q + 1'b1;
      if (&clr_addr_q) begin
        clr_busy_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_busy_q <= 1'b1;
      clr_addr_q <= '0;
    end else begin
      clr_busy_q <= clr_busy_d;
      clr_addr_q <= clr_addr_d;
    end
  end

  // The sweep owns the write port until every entry holds zero.
  assign we    = clr_busy_q || wr_en_i;
  assign waddr = clr_busy_q ? clr_addr_q : wr_addr_i;
  assign wdata = clr_busy_q ? '0 : wr_data_i;

  always_ff @(posedge clk_i) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rd_data_q <= mem[rd_addr_i];
  end

  assign rd_data_o = rd_data_q;
  assign ready_o   = !clr_busy_q;

endmodule

FILE: design/rsmp_mac.sv
// Shared multiply-accumulate unit with output scaling and saturation.
module rsmp_mac #(
  parameter int MAX_TAPS_PER_PHASE = 32,
  parameter int SAMPLE_WIDTH       = 16,
  parameter int COEF_WIDTH         = 18,
  parameter int COEF_FRAC          = 14
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  rsmp_pkg::mac_ctrl_t           ctrl_i,
  input  logic signed [COEF_WIDTH-1:0]  coef_i,
  input  logic signed [SAMPLE_WIDTH-1:0] sample_i,
  output logic                          busy_o,
  output logic [SAMPLE_WIDTH-1:0]       result_o,
  output logic                          sat_o
);
  import rsmp_pkg::*;

  localparam int PROD_W = SAMPLE_WIDTH + COEF_WIDTH;
  localparam int ACC_W  = PROD_W + $clog2(MAX_TAPS_PER_PHASE) + 1;

  logic                     v1_q, v2_q;
  logic signed [PROD_W-1:0] prod_q;
  logic signed [ACC_W-1:0]  acc_q;
  logic signed [ACC_W-1:0]  acc_shr;
  logic [ACC_W-SAMPLE_WIDTH:0] upper;

  // Operands arrive in the cycle after the issue (registered store read and tap).
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
    end else begin
      v1_q <= ctrl_i.vld;
      v2_q <= v1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (v1_q) begin
      prod_q <= coef_i * sample_i;
    end
    if (ctrl_i.clr) begin
      acc_q <= '0;
    end else if (v2_q) begin
      acc_q <= acc_q + ACC_W'(prod_q);
    end
  end

  assign busy_o  = v1_q || v2_q;
  assign acc_shr = acc_q >>> COEF_FRAC;
  assign upper   = acc_shr[ACC_W-1:SAMPLE_WIDTH-1];

  // The value fits when all bits above the sample width repeat its sign.
  always_comb begin
    sat_o    = !((&upper) || !(|upper));
    result_o = acc_shr[SAMPLE_WIDTH-1:0];
    if (sat_o) begin
      result_o = acc_shr[ACC_W-1] ? {1'b1, {(SAMPLE_WIDTH-1){1'b0}}}
                                  : {1'b0, {(SAMPLE_WIDTH-1){1'b1}}};
    end
  end

endmodule

FILE: design/rsmp_div.sv
// Bit-serial restoring divider for the phase update.
module rsmp_div #(
  parameter int T_W = 9,
  parameter int U_W = 5
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           start_i,
  input  logic [T_W-1:0] dividend_i,
  input  logic [U_W-1:0] divisor_i,
  output logic           busy_o,
  output logic [T_W-1:0] quo_o,
  output logic [U_W-1:0] rem_o
);
  import rsmp_pkg::*;

  localparam int CNT_W = $clog2(T_W + 1);

  logic             busy_q;
  logic [CNT_W-1:0] cnt_q;
  logic [T_W-1:0]   quo_q;
  logic [U_W-1:0]   rem_q;
  logic [U_W:0]     trial;
  logic             fits;

  assign trial = {rem_q, quo_q[T_W-1]};
  assign fits  = trial >= {1'b0, divisor_i};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else if (start_i) begin
      busy_q <= 1'b1;
      cnt_q  <= CNT_W'(T_W);
    end else if (busy_q) begin
      cnt_q <= cnt_q - 1'b1;
      if (cnt_q == CNT_W'(1)) begin
        busy_q <= 1'b0;
      end
    end
  end

  // One quotient bit per cycle, most significant first.
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      quo_q <= dividend_i;
      rem_q <= '0;
    end else if (busy_q) begin
      quo_q <= {quo_q[T_W-2:0], fits};
      rem_q <= fits ? U_W'(trial - {1'b0, divisor_i}) : trial[U_W-1:0];
    end
  end

  assign busy_o = busy_q;
  assign quo_o  = quo_q;
  assign rem_o  = rem_q;

endmodule

FILE: design/polyphase_resampler_top.sv
// Polyphase upsample, FIR filter, downsample engine (top level).
// Input stream s_axis: tuser selects the transaction kind. A coefficient
// transaction writes one prototype filter tap. A sample transaction shifts
// the sample into the delay line; while a skip count is pending it only
// counts down, otherwise it produces one or more output transactions on
// m_axis, the final one marked by tlast.
// Each output walks taps_per_phase coefficients through one shared multiplier,
// one tap per cycle, while a bit-serial divider updates the phase in
// parallel. Each output is paced by the multiply-accumulate walk, or by the
// 9-step divider for short filters.
// s_axis_tready_o stays low until the last output of a sample has been handed
// to the output register.
// After reset the coefficient store is swept to zero, all 512 entries, with
// s_axis_tready_o low; configuration writes are taken meanwhile.
// The output register holds one result; when the receiver stalls, the next
// result waits in the sequencer and no new input is taken.
// Configuration writes belong to idle periods only.
`include "polyphase_resampler_top_macros.svh"
module polyphase_resampler_top #(
  parameter int MAX_UP             = 16,
  parameter int MAX_TAPS_PER_PHASE = 32,
  parameter int SAMPLE_WIDTH       = 16,
  parameter int COEF_WIDTH         = 18,
  parameter int COEF_FRAC          = 14,
  localparam int IN_TDATA_W  =
    ((SAMPLE_WIDTH + rsmp_pkg::STORE_AW + COEF_WIDTH + 7) / 8) * 8,
  localparam int OUT_TDATA_W = ((SAMPLE_WIDTH + 7) / 8) * 8
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  // Configuration write port.
  input  logic                              cfg_we_i,
  input  logic [rsmp_pkg::CFG_IDX_W-1:0]    cfg_idx_i,
  input  logic [rsmp_pkg::CFG_DATA_W-1:0]   cfg_wdata_i,
  // Input stream.
  input  logic                              s_axis_tvalid_i,
  output logic                              s_axis_tready_o,
  input  logic [IN_TDATA_W-1:0]             s_axis_tdata_i,  // sample, coef_index, coef_value
  input  logic                              s_axis_tuser_i,  // func
  // Output stream.
  output logic                              m_axis_tvalid_o,
  input  logic                              m_axis_tready_i,
  output logic [OUT_TDATA_W-1:0]            m_axis_tdata_o,  // result_sample
  output logic                              m_axis_tuser_o,  // saturated
  output logic                              m_axis_tlast_o   // last
);
  import rsmp_pkg::*;

  localparam int U_W       = $clog2(MAX_UP + 1);
  localparam int PH_W      = (MAX_UP > 1) ? $clog2(MAX_UP) : 1;
  localparam int N_W       = PH_W;
  localparam int TP_W      = $clog2(MAX_TAPS_PER_PHASE + 1);
  localparam int TAP_IDX_W = (MAX_TAPS_PER_PHASE > 1) ? $clog2(MAX_TAPS_PER_PHASE) : 1;
  localparam int T_W       = $clog2(MAX_UP + MAX_DOWN);

  typedef enum logic [3:0] {
    S_IDLE  = 4'b0001,
    S_MAC   = 4'b0010,
    S_DRAIN = 4'b0100,
    S_EMIT  = 4'b1000
  } state_e;

  state_e                   state_q, state_d;
  logic [UP_REG_W-1:0]      up_q;
  logic [DOWN_REG_W-1:0]    down_q;
  logic [TAPS_REG_W-1:0]    taps_q;
  logic [U_W-1:0]           up_eff;
  logic [DOWN_REG_W-1:0]    down_eff;
  logic [TP_W-1:0]          taps_eff;

  logic [TAP_IDX_W-1:0]     j_q, j_d;
  logic [STORE_AW-1:0]      idx_q, idx_d;
  logic [N_W-1:0]           n_q, n_d;
  logic [PH_W-1:0]          phase_q, phase_d;
  logic [SKIP_W-1:0]        skip_q, skip_d, skip_val;

  logic signed [SAMPLE_WIDTH-1:0] dl_q [MAX_TAPS_PER_PHASE];
  logic signed [SAMPLE_WIDTH-1:0] dl_tap_q;

  logic                     in_acc, shift_dl, mem_we, mem_ready;
  logic signed [SAMPLE_WIDTH-1:0] in_sample;
  logic [STORE_AW-1:0]      in_coef_index;
  logic signed [COEF_WIDTH-1:0] in_coef_value;
  logic signed [COEF_WIDTH-1:0] coef_rd;

  mac_ctrl_t                mac_ctrl;
  logic                     mac_busy, mac_sat;
  logic [SAMPLE_WIDTH-1:0]  mac_res;

  logic                     div_start, div_busy;
  logic [T_W-1:0]           div_dividend, div_quo, quo_m1;
  logic [U_W-1:0]           div_rem;

  logic                     out_valid_q, out_sat_q, out_last_q, out_free, load_out, stop;
  logic [SAMPLE_WIDTH-1:0]  out_data_q;

  assign in_sample     = s_axis_tdata_i[SAMPLE_WIDTH-1:0];
  assign in_coef_index = s_axis_tdata_i[SAMPLE_WIDTH +: STORE_AW];
  assign in_coef_value = s_axis_tdata_i[SAMPLE_WIDTH + STORE_AW +: COEF_WIDTH];

  assign s_axis_tready_o = (state_q == S_IDLE) && mem_ready;
  assign in_acc          = s_axis_tvalid_i && s_axis_tready_o;

  // Configuration registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      up_q   <= UP_RESET;
      down_q <= DOWN_RESET;
      taps_q <= TAPS_RESET;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        REG_UP_RATE:        up_q   <= cfg_wdata_i[UP_REG_W-1:0];
        REG_DOWN_RATE:      down_q <= cfg_wdata_i[DOWN_REG_W-1:0];
        REG_TAPS_PER_PHASE: taps_q <= cfg_wdata_i[TAPS_REG_W-1:0];
        default: ;
      endcase
    end
  end

  // Zero and out-of-range register values are clamped into the working range.
  always_comb begin
    if (up_q == '0) begin
      up_eff = U_W'(1);
    end else if (32'(up_q) > MAX_UP) begin
      up_eff = U_W'(MAX_UP);
    end else begin
      up_eff = U_W'(up_q);
    end
    if (down_q == '0) begin
      down_eff = DOWN_REG_W'(1);
    end else if (32'(down_q) > MAX_DOWN) begin
      down_eff = DOWN_REG_W'(MAX_DOWN);
    end else begin
      down_eff = down_q;
    end
    if (taps_q == '0) begin
      taps_eff = TP_W'(1);
    end else if (32'(taps_q) > MAX_TAPS_PER_PHASE) begin
      taps_eff = TP_W'(MAX_TAPS_PER_PHASE);
    end else begin
      taps_eff = TP_W'(taps_q);
    end
  end

  assign out_free = !out_valid_q || m_axis_tready_i;
  assign stop     = (div_quo != '0) || (n_q == N_W'(MAX_UP - 1));
  assign quo_m1   = div_quo - 1'b1;

  always_comb begin
    if (div_quo == '0) begin
      skip_val = '0;
    end else if (quo_m1 > T_W'(SKIP_MAX)) begin
      skip_val = SKIP_W'(SKIP_MAX);
    end else begin
      skip_val = SKIP_W'(quo_m1);
    end
  end

  // Sequencer.
  always_comb begin
    state_d   = state_q;
    j_d       = j_q;
    idx_d     = idx_q;
    n_d       = n_q;
    phase_d   = phase_q;
    skip_d    = skip_q;
    mac_ctrl  = '0;
    div_start = 1'b0;
    load_out  = 1'b0;
    mem_we    = 1'b0;
    shift_dl  = 1'b0;
    unique case (state_q)
      S_IDLE: begin
        if (in_acc) begin
          if (s_axis_tuser_i == FUNC_COEF) begin
            mem_we = 1'b1;
          end else begin
            shift_dl = 1'b1;
            if (skip_q != '0) begin
              skip_d = skip_q - 1'b1;
            end else begin
              state_d      = S_MAC;
              j_d          = '0;
              idx_d        = STORE_AW'(phase_q);
              n_d          = '0;
              mac_ctrl.clr = 1'b1;
              div_start    = 1'b1;
            end
          end
        end
      end
      S_MAC: begin
        mac_ctrl.vld = 1'b1;
        j_d          = j_q + 1'b1;
        idx_d        = idx_q + STORE_AW'(up_eff);
        if (j_q == TAP_IDX_W'(taps_eff - 1'b1)) begin
          state_d = S_DRAIN;
        end
      end
      S_DRAIN: begin
        if (!mac_busy && !div_busy) begin
          state_d = S_EMIT;
        end
      end
      S_EMIT: begin
        if (out_free) begin
          load_out = 1'b1;
          phase_d  = PH_W'(div_rem);
          n_d      = n_q + 1'b1;
          if (stop) begin
            skip_d  = skip_val;
            state_d = S_IDLE;
          end else begin
            // Another output for the same sample, from the updated phase.
            state_d      = S_MAC;
            j_d          = '0;
            idx_d        = STORE_AW'(PH_W'(div_rem));
            mac_ctrl.clr = 1'b1;
            div_start    = 1'b1;
          end
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  // The divider always starts from the phase that the coming output uses.
  assign div_dividend = T_W'(phase_d) + T_W'(down_eff);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      j_q     <= '0;
      idx_q   <= '0;
      n_q     <= '0;
      phase_q <= '0;
      skip_q  <= '0;
    end else begin
      state_q <= state_d;
      j_q     <= j_d;
      idx_q   <= idx_d;
      n_q     <= n_d;
      phase_q <= phase_d;
      skip_q  <= skip_d;
    end
  end

  // Delay line, newest sample in entry zero.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < MAX_TAPS_PER_PHASE; i++) begin
        dl_q[i] <= '0;
      end
    end else if (shift_dl) begin
      for (int i = MAX_TAPS_PER_PHASE - 1; i > 0; i--) begin
        dl_q[i] <= dl_q[i-1];
      end
      dl_q[0] <= in_sample;
    end
  end

  always_ff @(posedge clk_i) begin
    if (mac_ctrl.vld) begin
      dl_tap_q <= dl_q[j_q];
    end
  end

  rsmp_coef_mem #(
    .COEF_WIDTH (COEF_WIDTH)
  ) u_coef_mem (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .wr_en_i   (mem_we),
    .wr_addr_i (in_coef_index),
    .wr_data_i (in_coef_value),
    .rd_addr_i (idx_q),
    .rd_data_o (coef_rd),
    .ready_o   (mem_ready)
  );

  rsmp_mac #(
    .MAX_TAPS_PER_PHASE (MAX_TAPS_PER_PHASE),
    .SAMPLE_WIDTH       (SAMPLE_WIDTH),
    .COEF_WIDTH         (COEF_WIDTH),
    .COEF_FRAC          (COEF_FRAC)
  ) u_mac (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .ctrl_i   (mac_ctrl),
    .coef_i   (coef_rd),
    .sample_i (dl_tap_q),
    .busy_o   (mac_busy),
    .result_o (mac_res),
    .sat_o    (mac_sat)
  );

  rsmp_div #(
    .T_W (T_W),
    .U_W (U_W)
  ) u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (div_dividend),
    .divisor_i  (up_eff),
    .busy_o     (div_busy),
    .quo_o      (div_quo),
    .rem_o      (div_rem)
  );

  // Output register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (load_out) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_out) begin
      out_data_q <= mac_res;
      out_sat_q  <= mac_sat;
      out_last_q <= stop;
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = OUT_TDATA_W'(out_data_q);
  assign m_axis_tuser_o  = out_sat_q;
  assign m_axis_tlast_o  = out_last_q;

  `RSMP_ASSERT(a_emit_units_idle, (state_q == S_EMIT) |-> (!mac_busy && !div_busy), "result taken while the multiplier or divider is still working")
  `RSMP_ASSERT(a_last_ends_item, (load_out && stop) |=> (state_q == S_IDLE && !mac_busy), "sequencer still busy after the final result of an item")
  `RSMP_ASSERT(a_no_load_over_full, (out_valid_q && !m_axis_tready_i) |-> !load_out, "output register overwritten while a result waits")
  `RSMP_ASSERT_ALWAYS(a_clear_before_work, (state_q != S_IDLE) |-> mem_ready, "coefficient sweep still running while an item is processed")

endmodule

FILE: tb/tb.sv
`timescale 1ns / 1ps
// Self-checking testbench for the polyphase up-FIR-down resampler top level.
module tb;
  import rsmp_pkg::*;

  localparam int SMP_W       = 16;
  localparam int CF_W        = 18;
  localparam int IN_W        = ((SMP_W + STORE_AW + CF_W + 7) / 8) * 8;
  localparam int OUT_W       = ((SMP_W + 7) / 8) * 8;
  localparam int UP_LIMIT    = 16;
  localparam int TAPS_LIMIT  = 32;
  localparam int FRAC_BITS   = 14;
  localparam int SETTLE_CYC  = 64;
  localparam int STALL_LIMIT = 5000;

  // Index with no register behind it; writes to it must change nothing.
  localparam logic [CFG_IDX_W-1:0] REG_SPARE = 2'd3;

  typedef enum logic [1:0] {ROW_SAMPLE, ROW_COEF, ROW_CFG} row_kind_e;

  typedef struct packed {
    row_kind_e              kind;
    logic [CFG_IDX_W-1:0]   reg_idx;
    logic [CF_W-1:0]        value;
    logic [STORE_AW-1:0]    coef_idx;
    logic                   typed;
    logic signed [SMP_W-1:0] exp_res;
    logic                   exp_sat;
  } stim_row_t;

  typedef struct packed {
    logic signed [SMP_W-1:0] res;
    logic                    sat;
    logic                    last;
  } resamp_out_t;

  logic                  clk_i;
  logic                  rst_ni;
  logic                  cfg_we_i;
  logic [CFG_IDX_W-1:0]  cfg_idx_i;
  logic [CFG_DATA_W-1:0] cfg_wdata_i;
  logic                  s_axis_tvalid_i;
  logic                  s_axis_tready_o;
  logic [IN_W-1:0]       s_axis_tdata_i;  // sample, coef_index, coef_value
  logic                  s_axis_tuser_i;  // func
  logic                  m_axis_tvalid_o;
  logic                  m_axis_tready_i;
  logic [OUT_W-1:0]      m_axis_tdata_o;  // result_sample
  logic                  m_axis_tuser_o;  // saturated
  logic                  m_axis_tlast_o;  // last

  polyphase_resampler_top uut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_we_i        (cfg_we_i),
    .cfg_idx_i       (cfg_idx_i),
    .cfg_wdata_i     (cfg_wdata_i),
    .s_axis_tvalid_i (s_axis_tvalid_i),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_axis_tdata_i),
    .s_axis_tuser_i  (s_axis_tuser_i),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .m_axis_tdata_o  (m_axis_tdata_o),
    .m_axis_tuser_o  (m_axis_tuser_o),
    .m_axis_tlast_o  (m_axis_tlast_o)
  );

  // Predictor state: register copies, delay line, coefficient store, phase, skip.
  logic [UP_REG_W-1:0]     up_reg;
  logic [DOWN_REG_W-1:0]   down_reg;
  logic [TAPS_REG_W-1:0]   taps_reg;
  logic signed [SMP_W-1:0] sample_hist [TAPS_LIMIT];
  logic signed [CF_W-1:0]  tap_coefs [STORE_DEPTH];
  int unsigned             phase_q;
  int unsigned             skip_q;

  resamp_out_t pending_outputs[$];
  stim_row_t   rows[$];
  int          errors;
  int          items_sent;
  int          quiet_cycles;
  bit          full_speed;

  always #5 clk_i = ~clk_i;

  function automatic int unsigned clamp_rate(input int unsigned v, input int unsigned hi);
    if (v == 0) return 1;
    if (v > hi) return hi;
    return v;
  endfunction

  // Shifts one sample in and queues every output it causes; returns their count.
  function automatic int filter_sample(input logic signed [SMP_W-1:0] x);
    int unsigned up, down, taps, t, adv;
    int          n;
    bit          done;
    longint      acc;
    resamp_out_t o;
    for (int i = TAPS_LIMIT - 1; i > 0; i--) sample_hist[i] = sample_hist[i-1];
    sample_hist[0] = x;
    if (skip_q != 0) begin
      skip_q--;
      return 0;
    end
    up   = clamp_rate(up_reg, UP_LIMIT);
    down = clamp_rate(down_reg, MAX_DOWN);
    taps = clamp_rate(taps_reg, TAPS_LIMIT);
    n    = 0;
    done = 1'b0;
    while (!done) begin
      acc = 0;
      for (int j = 0; j < taps; j++)
        acc += longint'(tap_coefs[(j * up + phase_q) % STORE_DEPTH]) * longint'(sample_hist[j]);
      acc   = acc >>> FRAC_BITS;
      o.sat = 1'b0;
      if (acc > 32767) begin
        acc   = 32767;
        o.sat = 1'b1;
      end else if (acc < -32768) begin
        acc   = -32768;
        o.sat = 1'b1;
      end
      o.res   = acc[SMP_W-1:0];
      o.last  = 1'b0;
      t       = phase_q + down;
      adv     = t / up;
      phase_q = t % up;
      n++;
      if (adv != 0 || n >= UP_LIMIT) begin
        if (adv == 0) adv = 1;
        adv = adv - 1;
        if (adv > SKIP_MAX) adv = SKIP_MAX;
        skip_q = adv;
        o.last = 1'b1;
        done   = 1'b1;
      end
      pending_outputs.push_back(o);
    end
    return n;
  endfunction

  task automatic add_sample(input int value, input bit typed = 1'b0, input int res = 0,
                            input bit sat = 1'b0);
    stim_row_t r;
    r         = '0;
    r.kind    = ROW_SAMPLE;
    r.value   = CF_W'(value);
    r.typed   = typed;
    r.exp_res = SMP_W'(res);
    r.exp_sat = sat;
    rows.push_back(r);
  endtask

  task automatic add_coef(input int idx, input int value);
    stim_row_t r;
    r          = '0;
    r.kind     = ROW_COEF;
    r.coef_idx = STORE_AW'(idx);
    r.value    = CF_W'(value);
    rows.push_back(r);
  endtask

  task automatic add_cfg(input logic [CFG_IDX_W-1:0] idx, input int value);
    stim_row_t r;
    r         = '0;
    r.kind    = ROW_CFG;
    r.reg_idx = idx;
    r.value   = CF_W'(value);
    rows.push_back(r);
  endtask

  task automatic send_item(input logic func, input logic [SMP_W-1:0] smp,
                           input logic [STORE_AW-1:0] cidx, input logic [CF_W-1:0] cval,
                           input bit typed, input logic signed [SMP_W-1:0] t_res,
                           input logic t_sat);
    int          n;
    resamp_out_t o;
    while (!full_speed && $urandom_range(0, 99) < 15) begin
      s_axis_tvalid_i <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid_i <= 1'b1;
    s_axis_tuser_i  <= func;
    s_axis_tdata_i  <= IN_W'({cval, cidx, smp});
    do @(posedge clk_i); while (!s_axis_tready_o);
    items_sent++;
    if (func == FUNC_COEF) begin
      tap_coefs[cidx] = cval;
    end else begin
      n = filter_sample(smp);
      if (typed) begin
        repeat (n) void'(pending_outputs.pop_back());
        o.res  = t_res;
        o.sat  = t_sat;
        o.last = 1'b1;
        pending_outputs.push_back(o);
      end
    end
  endtask

  // Stops sending and waits for every predicted output to come out.
  task automatic drain();
    s_axis_tvalid_i <= 1'b0;
    @(posedge clk_i);
    while (pending_outputs.size() != 0) @(posedge clk_i);
  endtask

  task automatic settle();
    drain();
    repeat (SETTLE_CYC) @(posedge clk_i);
  endtask

  task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= data;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    @(posedge clk_i);
    case (idx)
      REG_UP_RATE:        up_reg   = data[UP_REG_W-1:0];
      REG_DOWN_RATE:      down_reg = data[DOWN_REG_W-1:0];
      REG_TAPS_PER_PHASE: taps_reg = data[TAPS_REG_W-1:0];
      default: ;
    endcase
  endtask

  task automatic cfg_set(input int unsigned up, input int unsigned down, input int unsigned taps);
    settle();
    cfg_write(REG_UP_RATE, CFG_DATA_W'(up));
    cfg_write(REG_DOWN_RATE, CFG_DATA_W'(down));
    cfg_write(REG_TAPS_PER_PHASE, CFG_DATA_W'(taps));
  endtask

  always @(posedge clk_i) begin
    m_axis_tready_i <= full_speed || ($urandom_range(0, 99) >= 15);
  end

  always @(posedge clk_i) begin
    resamp_out_t want;
    if (rst_ni && m_axis_tvalid_o && m_axis_tready_i) begin
      if (pending_outputs.size() == 0) begin
        $error("unexpected output transaction: result_sample %0d", $signed(m_axis_tdata_o));
        errors++;
      end else begin
        want = pending_outputs.pop_front();
        if ($signed(m_axis_tdata_o[SMP_W-1:0]) !== want.res) begin
          $error("result_sample: expected %0d, got %0d", want.res,
                 $signed(m_axis_tdata_o[SMP_W-1:0]));
          errors++;
        end
        if (m_axis_tuser_o !== want.sat) begin
          $error("saturated: expected %0d, got %0d", want.sat, m_axis_tuser_o);
          errors++;
        end
        if (m_axis_tlast_o !== want.last) begin
          $error("last: expected %0d, got %0d", want.last, m_axis_tlast_o);
          errors++;
        end
      end
    end
  end

  // Ends the run if neither side completes a transaction for too long.
  always @(posedge clk_i) begin
    if ((s_axis_tvalid_i && s_axis_tready_o) || (m_axis_tvalid_o && m_axis_tready_i))
      quiet_cycles = 0;
    else
      quiet_cycles++;
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("** polyphase_resampler_top: FAILED **");
      $finish;
    end
  end

  initial begin
    stim_row_t             row;
    int unsigned           up_w, down_w, taps_w, cidx_hi;
    logic [STORE_AW-1:0]   cidx;
    logic [CF_W-1:0]       cval;
    logic [SMP_W-1:0]      smp;

    clk_i           = 1'b0;
    rst_ni          = 1'b0;
    cfg_we_i        = 1'b0;
    cfg_idx_i       = REG_UP_RATE;
    cfg_wdata_i     = '0;
    s_axis_tvalid_i = 1'b0;
    s_axis_tdata_i  = '0;
    s_axis_tuser_i  = FUNC_SAMPLE;
    m_axis_tready_i = 1'b0;
    errors          = 0;
    items_sent      = 0;
    quiet_cycles    = 0;
    full_speed      = 1'b0;

    up_reg   = UP_RESET;
    down_reg = DOWN_RESET;
    taps_reg = TAPS_RESET;
    foreach (sample_hist[i]) sample_hist[i] = '0;
    foreach (tap_coefs[i]) tap_coefs[i] = '0;
    phase_q = 0;
    skip_q  = 0;

    // Out of reset every tap is zero; then full-scale taps drive the output into clipping.
    add_sample(32767, 1'b1, 0, 1'b0);
    add_coef(0, 131071);
    add_coef(511, -131072);
    add_sample(32767, 1'b1, 32767, 1'b1);
    add_sample(-32768, 1'b1, -32768, 1'b1);
    add_sample(0, 1'b1, 0, 1'b0);
    add_coef(1, 16384);
    add_coef(2, -8192);
    add_sample(1234);
    // Rates above range clamp: sixteen branches, one output per branch, full length.
    add_cfg(REG_UP_RATE, 31);
    add_cfg(REG_DOWN_RATE, 0);
    add_cfg(REG_TAPS_PER_PHASE, 63);
    add_sample(-1);
    add_sample(20000);
    // Leave the phase at three, then drop to two branches so the phase is out of range.
    add_cfg(REG_DOWN_RATE, 5);
    add_sample(-20000);
    add_sample(7);
    add_cfg(REG_UP_RATE, 2);
    add_cfg(REG_TAPS_PER_PHASE, 0);
    add_sample(300);
    add_sample(-300);
    add_sample(32767);
    add_sample(-32768);
    add_sample(555);
    // Largest decimation with the largest interpolation, plus a write to the spare index.
    add_cfg(REG_UP_RATE, 31);
    add_cfg(REG_DOWN_RATE, 511);
    add_cfg(REG_TAPS_PER_PHASE, 1);
    add_cfg(REG_SPARE, 511);
    add_sample(-32768);

    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;

    for (int r = 0; r < rows.size(); r++) begin
      row = rows[r];
      case (row.kind)
        ROW_CFG: begin
          if (r == 0 || rows[r-1].kind != ROW_CFG) settle();
          cfg_write(row.reg_idx, row.value[CFG_DATA_W-1:0]);
        end
        ROW_COEF: send_item(FUNC_COEF, '0, row.coef_idx, row.value, 1'b0, '0, 1'b0);
        default:  send_item(FUNC_SAMPLE, row.value[SMP_W-1:0], '0, '0, row.typed,
                            row.exp_res, row.exp_sat);
      endcase
    end

    for (int ph = 0; ph < 7; ph++) begin
      if ($urandom_range(0, 99) < 15) begin
        // Raw nine-bit writes; the narrower registers keep only their low bits.
        up_w   = $urandom_range(0, 511);
        down_w = $urandom_range(0, 511);
        taps_w = $urandom_range(0, 511);
      end else begin
        up_w   = $urandom_range(1, UP_LIMIT);
        down_w = $urandom_range(1, 2 * up_w);
        taps_w = ($urandom_range(0, 99) < 15) ? $urandom_range(1, TAPS_LIMIT)
                                               : $urandom_range(1, 8);
      end
      cfg_set(up_w, down_w, taps_w);
      full_speed = (ph == 1);
      for (int k = 0; k < 14; k++) begin
        if (ph == 3 && k == 7) drain();
        if ($urandom_range(0, 99) < 25) begin
          cidx_hi = clamp_rate(taps_reg, TAPS_LIMIT) * clamp_rate(up_reg, UP_LIMIT) - 1;
          cidx = ($urandom_range(0, 99) < 75) ? STORE_AW'($urandom_range(0, cidx_hi))
                                               : STORE_AW'($urandom_range(0, STORE_DEPTH - 1));
          cval = ($urandom_range(0, 99) < 20) ? CF_W'($urandom())
                                               : CF_W'(int'($urandom_range(0, 8191)) - 4096);
          send_item(FUNC_COEF, SMP_W'($urandom()), cidx, cval, 1'b0, '0, 1'b0);
        end else begin
          smp = ($urandom_range(0, 99) < 70) ? SMP_W'($urandom())
                                              : SMP_W'(int'($urandom_range(0, 511)) - 256);
          send_item(FUNC_SAMPLE, smp, STORE_AW'($urandom()), CF_W'($urandom()),
                    1'b0, '0, 1'b0);
        end
      end
      full_speed = 1'b0;
    end

    drain();
    repeat (100) @(posedge clk_i);
    if (errors == 0)
      $display("** polyphase_resampler_top: PASSED **");
    else
      $display("** polyphase_resampler_top: FAILED **");
    $finish;
  end

endmodule

FILE: sim.f
+incdir+design
design/rsmp_pkg.sv
design/rsmp_coef_mem.sv
design/rsmp_mac.sv
design/rsmp_div.sv
design/polyphase_resampler_top.sv
tb/tb.sv
